FILE: hdl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is low.
`define SAL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// Next-cycle implication, disabled while reset is low.
`define SAL_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`else

`define SAL_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SAL_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: hdl/sal_pkg.sv
`timescale 1ns / 1ps

package sal_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int KEY_WIDTH_DEF = 32;

    localparam int OP_W    = 3;
    localparam int VALUE_W = 32;
    localparam int POS_W   = 4;
    localparam int FIDX_W  = 4;
    localparam int COUNT_W = 5;

    localparam int IN_DATA_W  = 40;   // 39 bits of fields, padded to bytes
    localparam int OUT_DATA_W = 48;   // 44 bits of fields, padded to bytes

    typedef enum logic [OP_W-1:0] {
        OP_INS_HEAD   = 3'd0,
        OP_INS_TAIL   = 3'd1,
        OP_INS_SORTED = 3'd2,
        OP_RM_HEAD    = 3'd3,
        OP_RM_TAIL    = 3'd4,
        OP_RM_VALUE   = 3'd5,
        OP_READ       = 3'd6,
        OP_FIND       = 3'd7
    } t_op;

    // Which cells count as "at or before the insert point".
    typedef enum logic [1:0] {
        LE_NONE = 2'd0,   // insert at head
        LE_ALL  = 2'd1,   // insert at tail
        LE_CMP  = 2'd2    // sorted insert, key compare
    } t_le_sel;

    // Which cell starts the left shift / match wave.
    typedef enum logic {
        EQ_HEAD = 1'b0,
        EQ_CMP  = 1'b1
    } t_eq_sel;

    typedef struct packed {
        t_le_sel le_sel;
        t_eq_sel eq_sel;
        logic    apply_ins;
        logic    apply_rm;
    } t_cell_ctl;

endpackage

FILE: hdl/sal_cell.sv
`timescale 1ns / 1ps

module sal_cell #(
    parameter int KEY_WIDTH = 32,
    parameter int IW        = 4,
    parameter int CW        = 5,
    parameter int INDEX     = 0
) (
    input  logic                   i_clk,
    input  sal_pkg::t_cell_ctl     i_ctl,
    input  logic [KEY_WIDTH-1:0]   i_key,
    input  logic [sal_pkg::POS_W-1:0] i_pos,
    input  logic [CW-1:0]          i_used,
    // neighbors
    input  logic [KEY_WIDTH-1:0]   i_slot_left,
    input  logic [KEY_WIDTH-1:0]   i_slot_right,
    input  logic                   i_le_left,
    input  logic                   i_ge_right,
    input  logic                   i_pre_left,
    input  logic [IW-1:0]          i_fi_left,
    input  logic [KEY_WIDTH-1:0]   i_rd_left,
    output logic [KEY_WIDTH-1:0]   o_slot,
    output logic                   o_le,
    output logic                   o_ge,
    output logic                   o_pre,
    output logic [IW-1:0]          o_fi,
    output logic [KEY_WIDTH-1:0]   o_rd
);
    import sal_pkg::*;

    logic [KEY_WIDTH-1:0] r_slot;
    logic                 r_ge;
    logic                 r_pre;
    logic [IW-1:0]        r_fi;
    logic [KEY_WIDTH-1:0] r_rd;
    logic                 valid;
    logic                 le;
    logic                 eq;

    assign valid = (CW'(INDEX) < i_used);

    always_comb begin
        case (i_ctl.le_sel)
            LE_NONE: le = 1'b0;
            LE_ALL:  le = valid;
            LE_CMP:  le = valid && ($signed(r_slot) <= $signed(i_key));
            default: le = 1'b0;
        endcase
        case (i_ctl.eq_sel)
            EQ_HEAD: eq = valid && (INDEX == 0);
            EQ_CMP:  eq = valid && (r_slot == i_key);
            default: eq = 1'b0;
        endcase
    end

    // Waves settle one cell per cycle while the slots hold still.
    always_ff @(posedge i_clk) begin
        r_ge  <= le | i_ge_right;
        r_pre <= eq | i_pre_left;
        r_fi  <= i_pre_left ? i_fi_left : IW'(INDEX);
        r_rd  <= (32'(i_pos) == 32'(INDEX)) ? r_slot : i_rd_left;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.apply_ins && !r_ge) begin
            r_slot <= i_le_left ? i_key : i_slot_left;
        end else if (i_ctl.apply_rm && r_pre) begin
            r_slot <= i_slot_right;
        end
    end

    assign o_slot = r_slot;
    assign o_le   = le;
    assign o_ge   = r_ge;
    assign o_pre  = r_pre;
    assign o_fi   = r_fi;
    assign o_rd   = r_rd;

endmodule

FILE: hdl/static_array_list_engine.sv
`timescale 1ns / 1ps
// Channel   | Dir | Fields (low bit up)
// ----------+-----+-------------------------------------------------------------
// s_axis    | in  | tdata: op[2:0], value[34:3], position[38:35], zero pad
// m_axis    | out | tdata: ok[0], read_value[32:1], found_index[36:33],
//           |     |        count[41:37], is_full[42], is_empty[43], zero pad
//
// After a word is accepted, the match, insert-point and read waves cross the row
// of cells one cell per cycle; the next word is taken only once the update is done.
// Reset (i_rst_n low, synchronous) clears the element count and control;
// slot contents stay undefined until written.
// Input is taken only when the engine is idle; a finished result sits in the
// output register so a new word may be accepted while it waits. The update
// stalls in its last cycle while the output register is still occupied.

`include "assert_macros.svh"

module static_array_list_engine #(
    parameter int DEPTH     = sal_pkg::DEPTH_DEF,
    parameter int KEY_WIDTH = sal_pkg::KEY_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [sal_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // op, value, position
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [sal_pkg::OUT_DATA_W-1:0] m_axis_tdata    // ok, read_value, found_index,
                                                           // count, is_full, is_empty
);
    import sal_pkg::*;

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_BUSY  = 3'b010,
        S_APPLY = 3'b100
    } t_state;

    t_state                r_state, n_state;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic [CW-1:0]         r_used, n_used;
    t_op                   r_op;
    logic [KEY_WIDTH-1:0]  r_key;
    logic [POS_W-1:0]      r_pos;
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic [KEY_WIDTH-1:0]  w_slot [DEPTH];
    logic                  w_le   [DEPTH];
    logic                  w_ge   [DEPTH];
    logic                  w_pre  [DEPTH];
    logic [IW-1:0]         w_fi   [DEPTH];
    logic [KEY_WIDTH-1:0]  w_rd   [DEPTH];

    t_cell_ctl             ctl;
    logic                  accept;
    logic                  out_free;
    logic                  do_apply;
    logic                  full;
    logic                  empty;
    logic                  found;
    logic                  ok;
    logic [VALUE_W-1:0]    rd_val;
    logic [FIDX_W-1:0]     fidx;

    // ---- handshake ----
    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign do_apply      = (r_state == S_APPLY) && out_free;

    assign full  = (r_used == CW'(DEPTH));
    assign empty = (r_used == '0);
    assign found = w_pre[DEPTH-1];

    // ---- sequencer ----
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (accept) begin
                    n_state = S_BUSY;
                end
            end
            S_BUSY: begin
                // let all waves cross every cell
                if (r_cnt == CW'(DEPTH)) begin
                    n_state = S_APPLY;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_APPLY: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= t_op'(s_axis_tdata[OP_W-1:0]);
            r_key <= KEY_WIDTH'(s_axis_tdata[OP_W +: VALUE_W]);
            r_pos <= s_axis_tdata[OP_W+VALUE_W +: POS_W];
        end
    end

    // ---- cell control and result ----
    always_comb begin
        ctl.le_sel    = LE_CMP;
        ctl.eq_sel    = EQ_CMP;
        ctl.apply_ins = 1'b0;
        ctl.apply_rm  = 1'b0;
        ok            = 1'b0;
        rd_val        = '0;
        fidx          = '0;
        n_used        = r_used;
        case (r_op)
            OP_INS_HEAD, OP_INS_TAIL, OP_INS_SORTED: begin
                if (r_op == OP_INS_HEAD) begin
                    ctl.le_sel = LE_NONE;
                end else if (r_op == OP_INS_TAIL) begin
                    ctl.le_sel = LE_ALL;
                end
                ok            = !full;
                ctl.apply_ins = do_apply && !full;
                if (!full) begin
                    n_used = r_used + 1'b1;
                end
            end
            OP_RM_HEAD: begin
                ctl.eq_sel   = EQ_HEAD;
                ok           = !empty;
                ctl.apply_rm = do_apply && !empty;
                if (!empty) begin
                    n_used = r_used - 1'b1;
                end
            end
            OP_RM_TAIL: begin
                ok = !empty;
                if (!empty) begin
                    n_used = r_used - 1'b1;
                end
            end
            OP_RM_VALUE: begin
                ok           = found;
                ctl.apply_rm = do_apply && found;
                if (found) begin
                    n_used = r_used - 1'b1;
                end
            end
            OP_READ: begin
                ok = (CW'(r_pos) < r_used) && (32'(r_pos) < 32'(DEPTH));
                if (ok) begin
                    rd_val = VALUE_W'(w_rd[DEPTH-1]);
                end
            end
            OP_FIND: begin
                ok = found;
                if (found) begin
                    fidx = FIDX_W'(w_fi[DEPTH-1]);
                end
            end
            default: begin
                ok = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (do_apply) begin
            r_used <= n_used;
        end
    end

    // ---- output register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (do_apply) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_apply) begin
            r_out_data <= {4'b0000,
                           (n_used == '0),
                           (n_used == CW'(DEPTH)),
                           COUNT_W'(n_used),
                           fidx,
                           rd_val,
                           ok};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // ---- row of cells ----
    for (genvar j = 0; j < DEPTH; j++) begin : g_cell
        logic [KEY_WIDTH-1:0] slot_left;
        logic [KEY_WIDTH-1:0] slot_right;
        logic                 le_left;
        logic                 ge_right;
        logic                 pre_left;
        logic [IW-1:0]        fi_left;
        logic [KEY_WIDTH-1:0] rd_left;

        if (j == 0) begin : g_head
            assign slot_left = r_key;
            assign le_left   = 1'b1;     // head takes the key when nothing sits before it
            assign pre_left  = 1'b0;
            assign fi_left   = '0;
            assign rd_left   = '0;
        end else begin : g_mid
            assign slot_left = w_slot[j-1];
            assign le_left   = w_le[j-1];
            assign pre_left  = w_pre[j-1];
            assign fi_left   = w_fi[j-1];
            assign rd_left   = w_rd[j-1];
        end

        if (j == DEPTH - 1) begin : g_tail
            assign slot_right = w_slot[j];
            assign ge_right   = 1'b0;
        end else begin : g_body
            assign slot_right = w_slot[j+1];
            assign ge_right   = w_ge[j+1];
        end

        sal_cell #(
            .KEY_WIDTH (KEY_WIDTH),
            .IW        (IW),
            .CW        (CW),
            .INDEX     (j)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (ctl),
            .i_key        (r_key),
            .i_pos        (r_pos),
            .i_used       (r_used),
            .i_slot_left  (slot_left),
            .i_slot_right (slot_right),
            .i_le_left    (le_left),
            .i_ge_right   (ge_right),
            .i_pre_left   (pre_left),
            .i_fi_left    (fi_left),
            .i_rd_left    (rd_left),
            .o_slot       (w_slot[j]),
            .o_le         (w_le[j]),
            .o_ge         (w_ge[j]),
            .o_pre        (w_pre[j]),
            .o_fi         (w_fi[j]),
            .o_rd         (w_rd[j])
        );
    end

    // ---- checks ----
    `SAL_ASSERT_IMP(a_used_range, i_clk, i_rst_n, 1'b1, r_used <= CW'(DEPTH))
    `SAL_ASSERT_NXT(a_used_hold, i_clk, i_rst_n, r_state != S_APPLY, $stable(r_used))
    `SAL_ASSERT_NXT(a_result_out, i_clk, i_rst_n, do_apply, r_out_valid)
    `SAL_ASSERT_IMP(a_count_match, i_clk, i_rst_n, r_out_valid, r_out_data[41:37] == COUNT_W'(r_used))

endmodule

FILE: tb/list_result_checker.sv
`timescale 1ns / 1ps

module list_result_checker #(
    parameter int DEPTH = sal_pkg::DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    input  logic [sal_pkg::IN_DATA_W-1:0]  i_s_tdata,   // op, value, position, zero pad
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    input  logic [sal_pkg::OUT_DATA_W-1:0] i_m_tdata,   // ok, read_value, found_index,
                                                        // count, is_full, is_empty, pad
    output int                             o_fail_count,
    output int                             o_pending
);
    import sal_pkg::*;

    typedef struct packed {
        logic               ok;
        logic [VALUE_W-1:0] read_value;
        logic [FIDX_W-1:0]  found_index;
        logic [COUNT_W-1:0] count;
        logic               is_full;
        logic               is_empty;
    } list_reply_t;

    // Shadow copy of the list; slots at or past list_len are never read.
    logic signed [VALUE_W-1:0] list_keys [DEPTH];
    int                        list_len;
    list_reply_t               expected_replies [$];

    function automatic list_reply_t apply_list_op(t_op op, logic signed [VALUE_W-1:0] key,
                                                  logic [POS_W-1:0] pos);
        list_reply_t r;
        int          i;
        int          j;
        r = '0;
        case (op)
            OP_INS_HEAD, OP_INS_TAIL, OP_INS_SORTED: begin
                if (list_len < DEPTH) begin
                    if (op == OP_INS_HEAD) begin
                        i = 0;
                    end else if (op == OP_INS_TAIL) begin
                        i = list_len;
                    end else begin
                        // walk back over larger keys only, so equal keys stay ahead
                        i = list_len;
                        while (i > 0 && list_keys[i-1] > key) i--;
                    end
                    for (j = list_len; j > i; j--) list_keys[j] = list_keys[j-1];
                    list_keys[i] = key;
                    list_len++;
                    r.ok = 1'b1;
                end
            end
            OP_RM_HEAD, OP_RM_TAIL, OP_RM_VALUE: begin
                if (op == OP_RM_HEAD) begin
                    i = 0;
                end else if (op == OP_RM_TAIL) begin
                    i = list_len - 1;
                end else begin
                    i = 0;
                    while (i < list_len && list_keys[i] != key) i++;
                end
                if (list_len > 0 && i < list_len) begin
                    for (j = i; j + 1 < list_len; j++) list_keys[j] = list_keys[j+1];
                    list_len--;
                    r.ok = 1'b1;
                end
            end
            OP_READ: begin
                if (pos < list_len) begin
                    r.ok         = 1'b1;
                    r.read_value = list_keys[pos];
                end
            end
            OP_FIND: begin
                i = 0;
                while (i < list_len && list_keys[i] != key) i++;
                if (i < list_len) begin
                    r.ok          = 1'b1;
                    r.found_index = FIDX_W'(i);
                end
            end
            default: ;
        endcase
        r.count    = COUNT_W'(list_len);
        r.is_full  = (list_len == DEPTH);
        r.is_empty = (list_len == 0);
        return r;
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        list_reply_t got;
        list_reply_t want;
        if (!i_rst_n) begin
            expected_replies.delete();
            list_len = 0;
        end else begin
            // retire the result first: it can never belong to a word taken this edge
            if (i_m_tvalid && i_m_tready) begin
                got.ok          = i_m_tdata[0];
                got.read_value  = i_m_tdata[32:1];
                got.found_index = i_m_tdata[36:33];
                got.count       = i_m_tdata[41:37];
                got.is_full     = i_m_tdata[42];
                got.is_empty    = i_m_tdata[43];
                if (expected_replies.size() == 0) begin
                    $error("result word with nothing outstanding: %h", i_m_tdata);
                    o_fail_count++;
                end else begin
                    want = expected_replies.pop_front();
                    check_field("ok", want.ok, got.ok);
                    check_field("read_value", longint'($signed(want.read_value)),
                                longint'($signed(got.read_value)));
                    check_field("found_index", want.found_index, got.found_index);
                    check_field("count", want.count, got.count);
                    check_field("is_full", want.is_full, got.is_full);
                    check_field("is_empty", want.is_empty, got.is_empty);
                end
            end
            if (i_s_tvalid && i_s_tready)
                expected_replies.push_back(apply_list_op(t_op'(i_s_tdata[2:0]),
                                                         i_s_tdata[34:3], i_s_tdata[38:35]));
        end
        o_pending = expected_replies.size();
    end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import sal_pkg::*;

    localparam int DEPTH        = DEPTH_DEF;
    localparam int WORD_CYCLES  = DEPTH + 3;     // accept-to-accept time of one word
    localparam int IDLE_LIMIT   = 4000;          // cycles with no handshake at all
    localparam int HOLD_CYCLES  = 400;           // one long sink back-pressure window
    localparam int HOLD_AFTER   = 60;            // results seen before that window opens
    localparam int RANDOM_WORDS = 550;
    localparam int MIX_WORDS    = 40;            // words per fill / drain / mixed stretch

    localparam logic [VALUE_W-1:0] KEY_MIN = 32'h8000_0000;
    localparam logic [VALUE_W-1:0] KEY_MAX = 32'h7FFF_FFFF;

    // op mix of a stretch: fill pushes the list to full, drain empties it
    typedef enum int {
        MIX_FILL  = 0,
        MIX_DRAIN = 1,
        MIX_ANY   = 2
    } mix_t;

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  s_axis_tvalid  = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata   = '0;   // op, value, position, zero pad
    logic                  m_axis_tvalid;
    logic                  m_axis_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;          // ok, read_value, found_index,
                                                  // count, is_full, is_empty, pad
    int                    fail_count;
    int                    pending;
    int                    results_seen   = 0;
    int                    idle_cycles    = 0;
    int                    words_sent     = 0;

    always #5 i_clk = ~i_clk;

    static_array_list_engine dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    list_result_checker #(.DEPTH(DEPTH)) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Sender gap before a word. Every fourth stretch of 60 words runs back to back;
    // otherwise gaps are mostly short, so they land on all cycles of a word's walk.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if ((words_sent / 60) % 4 == 1 || r < 40) return 0;
        if (r < 85) return $urandom_range(1, 4);
        if (r < 95) return $urandom_range(5, 25);
        return $urandom_range(30, 80);
    endfunction

    // Keys: mostly a small pool around zero plus both extremes, so finds, removes
    // by value and equal sorted keys hit often; the rest full-width random.
    function automatic logic [VALUE_W-1:0] pick_key();
        case ($urandom_range(0, 9))
            0:          return KEY_MIN;
            1:          return KEY_MAX;
            2, 3, 4, 5: return $urandom_range(0, 7) - 32'd3;
            default:    return $urandom();
        endcase
    endfunction

    function automatic t_op pick_op(mix_t mix);
        int r;
        r = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:  if (r < 70) return t_op'($urandom_range(OP_INS_HEAD, OP_INS_SORTED));
            MIX_DRAIN: if (r < 60) return t_op'($urandom_range(OP_RM_HEAD, OP_RM_VALUE));
            default: ;
        endcase
        return t_op'($urandom_range(OP_INS_HEAD, OP_FIND));
    endfunction

    // Drive one word at the falling edge and hold it until the rising edge that
    // takes it. tvalid is only lowered when a gap follows, so it never toggles twice
    // in one step.
    task automatic send_word(input t_op op, input logic [VALUE_W-1:0] value,
                             input logic [POS_W-1:0] pos);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata  <= {{(IN_DATA_W - OP_W - VALUE_W - POS_W){1'b0}}, pos, value, op};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        words_sent++;
    endtask

    // Stimulus and verdict
    initial begin
        mix_t mix;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // everything that can fail on an empty list
        send_word(OP_RM_HEAD,    '0, '0);
        send_word(OP_RM_TAIL,    '0, '0);
        send_word(OP_RM_VALUE,   '0, '0);
        send_word(OP_READ,       '0, '0);
        send_word(OP_FIND,       '0, '0);
        // extremes and sorted placement, equal keys going after their twins
        send_word(OP_INS_TAIL,   KEY_MAX,      '0);
        send_word(OP_INS_HEAD,   KEY_MIN,      '0);
        send_word(OP_INS_SORTED, 32'd0,        '0);
        send_word(OP_INS_SORTED, 32'd0,        '0);
        send_word(OP_INS_SORTED, 32'hFFFF_FFFF, '0);
        send_word(OP_INS_SORTED, KEY_MIN,      '0);
        send_word(OP_INS_SORTED, KEY_MAX,      '0);
        // reads past the end, at the end boundary and in range
        send_word(OP_READ,       '0, 4'd15);
        send_word(OP_READ,       '0, 4'd7);
        send_word(OP_READ,       '0, 4'd6);
        send_word(OP_READ,       '0, 4'd0);
        // find hit and miss, remove by value hit and miss, head and tail removal
        send_word(OP_FIND,       32'd0,     '0);
        send_word(OP_FIND,       32'd12345, '0);
        send_word(OP_RM_VALUE,   32'd0,     '0);
        send_word(OP_RM_VALUE,   32'd777,   '0);
        send_word(OP_RM_HEAD,    '0,        '0);
        send_word(OP_RM_TAIL,    '0,        '0);

        // random: fill / drain / mixed stretches, so full and empty recur
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            mix = mix_t'((n / MIX_WORDS) % 3);
            send_word(pick_op(mix), pick_key(), POS_W'($urandom_range(0, 15)));
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;

        // drain; a stuck result is caught by the idle watchdog
        while (pending != 0) @(negedge i_clk);
        repeat (3 * WORD_CYCLES) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) results_seen <= results_seen + 1;
    end

    // Sink: random stalls with no-stall stretches, plus one long hold so the
    // output register and the engine both fill and s_axis_tready drops.
    initial begin
        int  stall_left;
        int  cycle;
        int  r;
        bit  held;
        stall_left = 0;
        cycle      = 0;
        held       = 1'b0;
        forever begin
            @(negedge i_clk);
            cycle++;
            if (!held && results_seen >= HOLD_AFTER) begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if ((cycle / 400) % 4 == 2) begin
                m_axis_tready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    m_axis_tready <= 1'b1;
                end else begin
                    m_axis_tready <= 1'b0;
                    if (r < 90)      stall_left = $urandom_range(0, 2);
                    else if (r < 97) stall_left = $urandom_range(3, 9);
                    else             stall_left = $urandom_range(20, 60);
                end
            end
        end
    end

    // Watchdog: any handshake on either side restarts the count
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

FILE: files.f
+incdir+hdl
hdl/sal_pkg.sv
hdl/sal_cell.sv
hdl/static_array_list_engine.sv
tb/list_result_checker.sv
tb/tb_top.sv
